// File: hdl/frc_pkg.sv
// Shared constants for the fraction reduce and compare unit.
`timescale 1ns / 1ps
package frc_pkg;
  localparam int ValueWidthDefault = 32;
  localparam int OutNumWidth = 32;
  localparam int OutDenWidth = 31;
  localparam int InTdataWidth = 128;
  localparam int OutTdataWidth = 256;
  localparam logic [1:0] ORD_EQUAL = 2'd0;
  localparam logic [1:0] ORD_GREATER = 2'd1;
  localparam logic [1:0] ORD_LESS = 2'd2;
endpackage

// File: hdl/fraction_reduce_compare_unit.sv
// Top level: reduces two fractions by gcd, splits them and orders them.
//
//  channel | dir | tdata fields (low to high)
//  s_axis  | in  | num_a, den_a, num_b, den_b (32 each)
//  m_axis  | out | red_num_a, red_den_a, red_num_b, red_den_b, order, whole_a,
//          |     | frac_rem_a, whole_b, frac_rem_b, zero_den_a, zero_den_b
//
// One item at a time. Every division goes through one shared bit-serial
// divider; an item takes up to (k_a + k_b + 6) divisions, where k is the
// number of Euclid steps, plus the two cross products, which run side by
// side (shift-add). Reset is synchronous and clears the state machine and
// handshake flags. A result held on m_axis does not block input acceptance
// into the input register; the next item starts once the result has been
// taken.
`timescale 1ns / 1ps
module fraction_reduce_compare_unit #(
  parameter int VALUE_WIDTH = frc_pkg::ValueWidthDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // num_a, den_a, num_b, den_b
  input  logic [frc_pkg::InTdataWidth-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // red_num_a[31:0] red_den_a[62:32] red_num_b[94:63] red_den_b[125:95]
  // order[127:126] whole_a[159:128] frac_rem_a[190:160] whole_b[222:191]
  // frac_rem_b[253:223] zero_den_a[254] zero_den_b[255]
  output logic [frc_pkg::OutTdataWidth-1:0]  m_axis_tdata
);
  import frc_pkg::*;

  localparam int W = VALUE_WIDTH;
  localparam int MW = 2 * W;
  localparam int CW = $clog2(W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_GCD_START, S_GCD_WAIT, S_RED_NUM, S_RED_DEN,
    S_WHOLE, S_WHOLE_WAIT, S_NEXT, S_MUL, S_DONE
  } state_t;

  state_t          state;
  logic            in_full;
  logic [InTdataWidth-1:0] in_buf;
  logic            side;          // 0: fraction a, 1: fraction b
  logic [W-1:0]    ga, gb;        // Euclid operands
  logic [W-1:0]    mn [2];        // magnitudes of numerators
  logic [W-1:0]    md [2];
  logic            ng [2];        // numerator negative after sign fix
  logic [W-1:0]    rn [2];        // reduced magnitudes
  logic [W-1:0]    rd [2];
  logic [W-1:0]    wq [2];
  logic [W-1:0]    wr [2];
  logic            dstart;
  logic [W-1:0]    dend, dsor;
  logic            ddone;
  logic [W-1:0]    dq, dr;
  logic [MW-1:0]   pl, pr, acl, acr;
  logic [W-1:0]    mbl, mbr;
  logic [CW-1:0]   mcnt;
  logic            mul_phase;
  logic [1:0]      div_kind;      // 0 gcd, 1 num, 2 den, 3 whole

  localparam logic [1:0] K_GCD = 2'd0;
  localparam logic [1:0] K_NUM = 2'd1;
  localparam logic [1:0] K_DEN = 2'd2;
  localparam logic [1:0] K_WHL = 2'd3;

  // Saturate the most negative code and take a sign/magnitude pair
  function automatic logic [W:0] term(input logic [31:0] raw);
    logic [W-1:0] v;
    logic [W-1:0] m;
    v = raw[W-1:0];
    if (v[W-1]) begin
      m = ~v + 1'b1;
      if (m[W-1]) m = {1'b0, {(W-1){1'b1}}};
    end else begin
      m = v;
    end
    return {v[W-1], m};
  endfunction

  // Two's complement of a magnitude with a sign, widened to the port
  function automatic logic [31:0] signed_out(input logic neg, input logic [W-1:0] m);
    logic [31:0] e;
    e = 32'(m);
    return neg ? (~e + 1'b1) : e;
  endfunction

  frc_divider #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(dend), .divisor(dsor),
    .done(ddone), .quotient(dq), .remainder(dr)
  );

  assign s_axis_tready = !in_full;

  // Hold items, sequence the reduction, and run the cross products
  always_ff @(posedge clk) begin
    dstart <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      in_full <= 1'b0;
      m_axis_tvalid <= 1'b0;
      side <= 1'b0;
      dstart <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_full <= 1'b1;
        in_buf <= s_axis_tdata;
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_full && !m_axis_tvalid) state <= S_LOAD;
        end
        S_LOAD: begin
          logic [W:0] ta, tb, tc, td;
          ta = term(in_buf[31:0]);
          tb = term(in_buf[63:32]);
          tc = term(in_buf[95:64]);
          td = term(in_buf[127:96]);
          mn[0] <= ta[W-1:0];
          md[0] <= tb[W-1:0];
          ng[0] <= (ta[W] ^ tb[W]) && (ta[W-1:0] != '0);
          mn[1] <= tc[W-1:0];
          md[1] <= td[W-1:0];
          ng[1] <= (tc[W] ^ td[W]) && (tc[W-1:0] != '0);
          in_full <= 1'b0;
          side <= 1'b0;
          ga <= ta[W-1:0];
          gb <= tb[W-1:0];
          state <= S_GCD_START;
        end
        S_GCD_START: begin
          if (gb == '0) begin
            if (ga == '0) begin
              rn[side] <= mn[side];
              rd[side] <= md[side];
              state <= S_WHOLE;
            end else begin
              state <= S_RED_NUM;
            end
          end else begin
            dend <= ga;
            dsor <= gb;
            dstart <= 1'b1;
            div_kind <= K_GCD;
            state <= S_GCD_WAIT;
          end
        end
        S_GCD_WAIT: begin
          if (ddone) begin
            case (div_kind)
              K_GCD: begin
                ga <= gb;
                gb <= dr;
                state <= S_GCD_START;
              end
              K_NUM: begin
                rn[side] <= dq;
                state <= S_RED_DEN;
              end
              K_DEN: begin
                rd[side] <= dq;
                state <= S_WHOLE;
              end
              default: state <= S_GCD_START;
            endcase
          end
        end
        S_RED_NUM: begin
          dend <= mn[side];
          dsor <= ga;
          dstart <= 1'b1;
          div_kind <= K_NUM;
          state <= S_GCD_WAIT;
        end
        S_RED_DEN: begin
          dend <= md[side];
          dsor <= ga;
          dstart <= 1'b1;
          div_kind <= K_DEN;
          state <= S_GCD_WAIT;
        end
        S_WHOLE: begin
          if (rd[side] == '0) begin
            wq[side] <= '0;
            wr[side] <= '0;
            state <= S_NEXT;
          end else begin
            dend <= rn[side];
            dsor <= rd[side];
            dstart <= 1'b1;
            div_kind <= K_WHL;
            state <= S_WHOLE_WAIT;
          end
        end
        S_WHOLE_WAIT: begin
          if (ddone) begin
            wq[side] <= dq;
            wr[side] <= dr;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (!side) begin
            side <= 1'b1;
            ga <= mn[1];
            gb <= md[1];
            state <= S_GCD_START;
          end else begin
            // left = |a.num| * b.den, right = |b.num| * a.den
            acl <= '0;
            acr <= '0;
            pl <= MW'(rn[0]);
            pr <= MW'(rn[1]);
            mbl <= rd[1];
            mbr <= rd[0];
            mcnt <= CW'(W);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mbl[0]) acl <= acl + pl;
          if (mbr[0]) acr <= acr + pr;
          pl <= pl << 1;
          pr <= pr << 1;
          mbl <= mbl >> 1;
          mbr <= mbr >> 1;
          mcnt <= mcnt - 1'b1;
          if (mcnt == CW'(1)) state <= S_DONE;
        end
        S_DONE: begin
          logic lz, rz;
          logic [1:0] ord;
          lz = (acl == '0);
          rz = (acr == '0);
          // Order signed products from sign and magnitude
          if ((lz || rz) ? (lz && rz) : (ng[0] == ng[1] && acl == acr))
            ord = ORD_EQUAL;
          else if (lz) ord = ng[1] ? ORD_GREATER : ORD_LESS;
          else if (rz) ord = ng[0] ? ORD_LESS : ORD_GREATER;
          else if (ng[0] != ng[1]) ord = ng[0] ? ORD_LESS : ORD_GREATER;
          else if (ng[0]) ord = (acl < acr) ? ORD_GREATER : ORD_LESS;
          else ord = (acl > acr) ? ORD_GREATER : ORD_LESS;
          m_axis_tdata[31:0]    <= signed_out(ng[0], rn[0]);
          m_axis_tdata[62:32]   <= 31'(rd[0]);
          m_axis_tdata[94:63]   <= signed_out(ng[1], rn[1]);
          m_axis_tdata[125:95]  <= 31'(rd[1]);
          m_axis_tdata[127:126] <= ord;
          m_axis_tdata[159:128] <= signed_out(ng[0], wq[0]);
          m_axis_tdata[190:160] <= 31'(wr[0]);
          m_axis_tdata[222:191] <= signed_out(ng[1], wq[1]);
          m_axis_tdata[253:223] <= 31'(wr[1]);
          m_axis_tdata[254]     <= (rd[0] == '0);
          m_axis_tdata[255]     <= (rd[1] == '0);
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mul_phase = (state == S_MUL);

`ifndef SYNTHESIS
  // The divider is never started during the cross-product multiply
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    dstart |-> !mul_phase) else $error("divider start during multiply");
  // A new result appears only from the final step
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_DONE) else $error("stray result");
  // The order code never takes the unused value
  a_order_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[127:126] != 2'd3) else $error("bad order");
`endif
endmodule

// File: hdl/frc_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module frc_divider #(
  parameter int W = frc_pkg::ValueWidthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  import frc_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [CW-1:0] count;
  logic          busy;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // Shift one dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial = {rem, quo[W-1]};
    diff  = trial - {1'b0, dvs};
  end

  // Advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      count <= CW'(W);
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
      count <= count - 1'b1;
      if (count == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
endmodule
